FILE: design/otq_pkg.sv
`default_nettype none
package otq_pkg;
   localparam logic [1:0] REQ_SCHEDULE = 2'd0;
   localparam logic [1:0] REQ_CANCEL   = 2'd1;
   localparam logic [1:0] REQ_TICK     = 2'd2;
   localparam logic [1:0] REQ_IGNORED  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_TRUNC     = 2'd3;

   localparam logic [31:0] EMPTY_TIMEOUT_RESET = 32'h4000_0000;
   localparam logic [47:0] DEADLINE_MAX = 48'hFFFF_FFFF_FFFF;

   localparam logic [0:0] ADDR_EMPTY_TIMEOUT = 1'b0;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [47:0] deadline_ms;
      logic [31:0] interval_ms;
      logic [15:0] timer_handle;
      logic [47:0] now_ms;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] result_handle;
      logic        fired;
      logic [31:0] next_timeout;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [47:0] deadline;
      logic [31:0] interval;
      logic [31:0] order;
   } slot_type;
endpackage
`default_nettype wire

FILE: design/ordered_timer_queue.sv
// Channel  | Direction | Handshake          | Payload
// req      | in        | req_valid/req_stall | otq_pkg::req_type_type
// rsp      | out       | rsp_valid/rsp_stall | otq_pkg::rsp_type
// csr      | in        | APB write/read      | empty_timeout at address 0
// A schedule or cancel is decided from the registered request and its result is
// registered. A tick rescans the slot memory, one slot per cycle, for every item
// it produces: the first item follows a full scan, each later one follows the
// write-back of its predecessor, a full scan and its issue.
// Reset clears slot valid bits, generations, sequence counter and control state,
// and sets empty_timeout to EMPTY_TIMEOUT_RESET. A stalled result holds the
// sequencer; no new item is taken until the last result of the current one has been delivered.
`default_nettype none
module ordered_timer_queue #(
   parameter int TIMER_SLOTS        = 16,
   parameter int MAX_FIRES_PER_TICK = 63
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire otq_pkg::req_type_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output otq_pkg::rsp_type          rsp_data,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [1:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import otq_pkg::*;

   localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CW = $clog2(MAX_FIRES_PER_TICK + 1);
   localparam logic [IW:0] NSLOT = (IW + 1)'(TIMER_SLOTS);

   localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DECIDE = 3'd2,
                          S_FIRE = 3'd3, S_WB = 3'd5;

   slot_type mem [TIMER_SLOTS];
   slot_type rd_ff;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   slot_type      wr_data;

   logic [TIMER_SLOTS-1:0] valid_ff;
   logic [11:0] gen_ff [TIMER_SLOTS];
   logic [31:0] seq_ff, seq_in;
   logic [31:0] empty_ff;

   logic [2:0] state_ff, state_in;
   req_type_type req_ff;
   logic [IW:0] scan_ff, scan_in;      // read address issued
   logic [IW:0] rdix_ff;               // index of data in rd_ff
   logic        rdv_ff;
   logic        found_ff, found_in;
   logic [IW-1:0] best_ff, best_in;
   slot_type    bslot_ff, bslot_in;
   logic [CW-1:0] nfire_ff, nfire_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rspv_ff, rspv_in;

   logic [IW-1:0] rd_addr;
   assign rd_addr = scan_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:1] == 1'(ADDR_EMPTY_TIMEOUT)) ? empty_ff : 32'd0;

   function automatic logic [15:0] handle_of(logic [11:0] g, logic [IW-1:0] i);
      logic [31:0] h;
      h = ({20'd0, g} << IW) | 32'(i);
      return h[15:0];
   endfunction

   logic lowest_free_ok;
   logic [IW-1:0] lowest_free;
   logic cancel_hit;
   logic [IW-1:0] cancel_ix;
   always_comb begin
      lowest_free_ok = 1'b0;
      lowest_free = '0;
      for (int k = TIMER_SLOTS - 1; k >= 0; k--) begin
         if (!valid_ff[k]) begin
            lowest_free_ok = 1'b1;
            lowest_free = IW'(k);
         end
      end
      cancel_hit = 1'b0;
      cancel_ix = '0;
      for (int k = 0; k < TIMER_SLOTS; k++) begin
         if (valid_ff[k] && handle_of(gen_ff[k], IW'(k)) == req_ff.timer_handle) begin
            cancel_hit = 1'b1;
            cancel_ix = IW'(k);
         end
      end
   end

   // candidate compare for scan
   logic cand_ok, better;
   logic [48:0] rearm;
   logic [47:0] rearm_sat, diff;
   always_comb begin
      cand_ok = rdv_ff && valid_ff[rdix_ff[IW-1:0]];
      better = !found_ff || (rd_ff.deadline < bslot_ff.deadline) ||
               (rd_ff.deadline == bslot_ff.deadline && rd_ff.order < bslot_ff.order);
      rearm = {1'b0, bslot_ff.deadline} + 49'(bslot_ff.interval);
      rearm_sat = rearm[48] ? DEADLINE_MAX : rearm[47:0];
      diff = bslot_ff.deadline - req_ff.now_ms;
   end

   assign req_stall = (state_ff != S_IDLE) || rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      scan_in = scan_ff;
      found_in = found_ff;
      best_in = best_ff;
      bslot_in = bslot_ff;
      nfire_in = nfire_ff;
      rsp_in = rsp_ff;
      rspv_in = rspv_ff && rsp_stall;
      seq_in = seq_ff;
      wr_en = 1'b0;
      wr_addr = best_ff;
      wr_data = bslot_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               scan_in = '0;
               found_in = 1'b0;
               nfire_in = '0;
               state_in = (req_data.req_type == REQ_TICK) ? S_SCAN : S_DECIDE;
               if (req_data.req_type == REQ_IGNORED) state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (scan_ff != NSLOT) scan_in = scan_ff + 1'b1;
            if (cand_ok && better) begin
               found_in = 1'b1;
               best_in = rdix_ff[IW-1:0];
               bslot_in = rd_ff;
            end
            if (rdv_ff && rdix_ff == NSLOT - 1'b1) state_in = S_FIRE;
         end
         S_FIRE: begin
            if (!rspv_ff || !rsp_stall) begin
               rsp_in = '0;
               rspv_in = 1'b1;
               if (found_ff && bslot_ff.deadline <= req_ff.now_ms &&
                   32'(nfire_ff) < 32'(MAX_FIRES_PER_TICK)) begin
                  rsp_in.fired = 1'b1;
                  rsp_in.result_handle = handle_of(gen_ff[best_ff], best_ff);
                  nfire_in = nfire_ff + 1'b1;
                  state_in = S_WB;
               end else begin
                  rsp_in.last = 1'b1;
                  if (found_ff && bslot_ff.deadline <= req_ff.now_ms) begin
                     rsp_in.status = found_ff && 32'(nfire_ff) >= 32'(MAX_FIRES_PER_TICK)
                                     ? ST_TRUNC : ST_OK;
                     rsp_in.next_timeout = '0;
                  end else if (!found_ff) begin
                     rsp_in.next_timeout = empty_ff;
                  end else begin
                     rsp_in.next_timeout = (diff[47:32] != 16'd0) ? 32'hFFFF_FFFF
                                                                 : diff[31:0];
                  end
                  state_in = S_IDLE;
               end
            end
         end
         S_WB: begin
            if (bslot_ff.interval != 32'd0) begin
               wr_en = 1'b1;
               seq_in = seq_ff + 1'b1;
               wr_data.deadline = rearm_sat;
               wr_data.order = seq_ff + 1'b1;
            end
            scan_in = '0;
            found_in = 1'b0;
            state_in = S_SCAN;
         end
         S_DECIDE: begin
            if (!rspv_ff || !rsp_stall) begin
               rsp_in = '0;
               rsp_in.last = 1'b1;
               rspv_in = 1'b1;
               if (req_ff.req_type == REQ_SCHEDULE) begin
                  if (lowest_free_ok) begin
                     wr_en = 1'b1;
                     wr_addr = lowest_free;
                     wr_data.deadline = req_ff.deadline_ms;
                     wr_data.interval = req_ff.interval_ms;
                     wr_data.order = seq_ff + 1'b1;
                     seq_in = seq_ff + 1'b1;
                     rsp_in.result_handle =
                        handle_of(gen_ff[lowest_free] + 1'b1, lowest_free);
                  end else begin
                     rsp_in.status = ST_FULL;
                  end
               end else if (!cancel_hit) begin
                  rsp_in.status = ST_NOT_FOUND;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         seq_ff <= '0;
         empty_ff <= EMPTY_TIMEOUT_RESET;
         rspv_ff <= 1'b0;
         rdv_ff <= 1'b0;
         found_ff <= 1'b0;
         nfire_ff <= '0;
         scan_ff <= '0;
         rdix_ff <= '0;
         for (int k = 0; k < TIMER_SLOTS; k++) gen_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         seq_ff <= seq_in;
         rspv_ff <= rspv_in;
         found_ff <= found_in;
         nfire_ff <= nfire_in;
         scan_ff <= scan_in;
         rdix_ff <= scan_ff;
         rdv_ff <= (state_ff == S_SCAN) && (scan_ff != NSLOT);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[1:1] == 1'(ADDR_EMPTY_TIMEOUT))
            empty_ff <= csr_pwdata;
         if (state_ff == S_DECIDE && (!rspv_ff || !rsp_stall)) begin
            if (req_ff.req_type == REQ_SCHEDULE && lowest_free_ok) begin
               valid_ff[lowest_free] <= 1'b1;
               gen_ff[lowest_free] <= gen_ff[lowest_free] + 1'b1;
            end else if (req_ff.req_type == REQ_CANCEL && cancel_hit) begin
               valid_ff[cancel_ix] <= 1'b0;
            end
         end
         if (state_ff == S_WB && bslot_ff.interval == 32'd0)
            valid_ff[best_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      bslot_ff <= bslot_in;
      rsp_ff <= rsp_in;
      if (req_valid && !req_stall) req_ff <= req_data;
   end
endmodule
`default_nettype wire

FILE: dv/ordered_timer_queue_tb.sv
`default_nettype none
module ordered_timer_queue_tb;
   import otq_pkg::*;

   localparam int SLOTS     = 16;
   localparam int FIRE_CAP  = 63;
   localparam int IDX_BITS  = 4;
   localparam int N_RANDOM  = 330;
   localparam longint CYCLE_LIMIT = 4_000_000;

   // Mirror of the timer table; predicts the result items of each request.
   class timer_scoreboard;
      bit          armed [SLOTS];
      bit [47:0]   due [SLOTS];
      bit [31:0]   period [SLOTS];
      bit [31:0]   order [SLOTS];
      bit [11:0]   gen [SLOTS];
      bit [31:0]   seq_count;
      bit [31:0]   empty_value;
      rsp_type     pending[$];
      int          errors;
      int          n_fired, n_trunc, n_full, n_missing, n_checked;

      function void clear();
         foreach (armed[i]) begin
            armed[i] = 0; due[i] = '0; period[i] = '0; order[i] = '0; gen[i] = '0;
         end
         seq_count = '0;
         empty_value = EMPTY_TIMEOUT_RESET;
         pending.delete();
      endfunction

      function bit [15:0] handle_of(int i);
         return 16'((32'(gen[i]) << IDX_BITS) | i);
      endfunction

      function int earliest(bit only_due, bit [47:0] now);
         int best;
         best = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (!armed[i]) continue;
            if (only_due && due[i] > now) continue;
            if (best < 0 || due[i] < due[best] ||
                (due[i] == due[best] && order[i] < order[best]))
               best = i;
         end
         return best;
      endfunction

      function void push(bit [1:0] st, bit [15:0] h, bit f, bit [31:0] nt, bit l);
         rsp_type r;
         r.status = st; r.result_handle = h; r.fired = f; r.next_timeout = nt; r.last = l;
         pending.push_back(r);
      endfunction

      function void note_request(req_type_type q);
         int s, n;
         bit [1:0] st;
         bit [48:0] sum;
         bit [47:0] diff;
         bit [31:0] nt;
         case (q.req_type)
            REQ_SCHEDULE: begin
               s = -1;
               for (int i = 0; i < SLOTS; i++)
                  if (s < 0 && !armed[i]) s = i;
               if (s < 0) begin
                  push(ST_FULL, '0, 0, '0, 1);
                  n_full++;
               end else begin
                  armed[s] = 1; due[s] = q.deadline_ms; period[s] = q.interval_ms;
                  seq_count++;
                  order[s] = seq_count;
                  gen[s] = gen[s] + 1;
                  push(ST_OK, handle_of(s), 0, '0, 1);
               end
            end
            REQ_CANCEL: begin
               s = -1;
               for (int i = 0; i < SLOTS; i++)
                  if (s < 0 && armed[i] && handle_of(i) == q.timer_handle) s = i;
               if (s < 0) begin
                  push(ST_NOT_FOUND, '0, 0, '0, 1);
                  n_missing++;
               end else begin
                  armed[s] = 0;
                  push(ST_OK, '0, 0, '0, 1);
               end
            end
            REQ_TICK: begin
               n = 0;
               st = ST_OK;
               forever begin
                  s = earliest(1, q.now_ms);
                  if (s < 0) break;
                  if (n >= FIRE_CAP) begin
                     st = ST_TRUNC;
                     n_trunc++;
                     break;
                  end
                  push(ST_OK, handle_of(s), 1, '0, 0);
                  n++;
                  n_fired++;
                  if (period[s] == 0) armed[s] = 0;
                  else begin
                     sum = 49'(due[s]) + 49'(period[s]);
                     due[s] = sum[48] ? DEADLINE_MAX : sum[47:0];
                     seq_count++;
                     order[s] = seq_count;
                  end
               end
               s = earliest(0, q.now_ms);
               if (s < 0) nt = empty_value;
               else if (due[s] <= q.now_ms) nt = '0;
               else begin
                  diff = due[s] - q.now_ms;
                  nt = (diff > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
               end
               push(st, '0, 0, nt, 1);
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (pending.size() == 0) begin
            $error("result with no expectation: %p", got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         n_checked++;
         if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
         end
         if (got.result_handle !== exp.result_handle) begin
            $error("result_handle: expected %h, got %h", exp.result_handle,
                   got.result_handle); errors++;
         end
         if (got.fired !== exp.fired) begin
            $error("fired: expected %0d, got %0d", exp.fired, got.fired); errors++;
         end
         if (got.next_timeout !== exp.next_timeout) begin
            $error("next_timeout: expected %0d, got %0d", exp.next_timeout,
                   got.next_timeout); errors++;
         end
         if (got.last !== exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, got.last); errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_stall;
   req_type_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 0;
   rsp_type      rsp_data;
   logic         csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [1:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   timer_scoreboard board;
   longint       cycles = 0;
   bit           stalls_on = 1;
   bit [47:0]    clock_ms;
   bit [15:0]    given[$];

   ordered_timer_queue uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result side: check accepted items, then draw a random stall after each one while stalls are on.
   int stall_left = 0;
   int rsp_wait;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            board.check_result(rsp_data);
            if (rsp_data.status == ST_OK && rsp_data.result_handle != 0 &&
                !rsp_data.fired)
               given.push_back(rsp_data.result_handle);
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= (stall_left > 1);
         end else if (rsp_valid && !rsp_stall && stalls_on) begin
            rsp_wait = $urandom_range(0, 7);
            stall_left <= rsp_wait;
            rsp_stall <= (rsp_wait != 0);
         end else rsp_stall <= 0;
      end
   end

   task automatic csr_write(bit [31:0] value);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {ADDR_EMPTY_TIMEOUT, 1'b0}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      board.empty_value = value;
   endtask

   task automatic send(req_type_type q);
      int gap;
      gap = stalls_on ? $urandom_range(0, 7) : 0;
      repeat (gap) @(posedge clock);
      req_valid <= 1;
      req_data <= q;
      do @(posedge clock); while (req_stall);
      board.note_request(q);
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic req_type_type make(bit [1:0] kind, bit [47:0] dl, bit [31:0] iv,
                                         bit [15:0] h, bit [47:0] now);
      req_type_type q;
      q.req_type = kind; q.deadline_ms = dl; q.interval_ms = iv;
      q.timer_handle = h; q.now_ms = now;
      return q;
   endfunction

   function automatic bit [47:0] rand48();
      return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
   endfunction

   // Random item: mostly schedules near the running clock and advancing ticks.
   function automatic req_type_type random_item();
      int pick;
      bit [15:0] h;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         return make(REQ_SCHEDULE,
                     ($urandom_range(0, 9) == 0) ? rand48() :
                     clock_ms + $urandom_range(0, 200),
                     ($urandom_range(0, 2) == 0) ? 32'd0 :
                     ($urandom_range(0, 9) == 0) ? $urandom() :
                     32'($urandom_range(1, 60)),
                     16'($urandom()), rand48());
      if (pick < 60) begin
         h = (given.size() != 0 && $urandom_range(0, 3) != 0) ?
             given[$urandom_range(0, given.size() - 1)] : 16'($urandom());
         return make(REQ_CANCEL, rand48(), $urandom(), h, rand48());
      end
      if (pick < 97)
         return make(REQ_TICK, rand48(), $urandom(), 16'($urandom()),
                     clock_ms + $urandom_range(0, 80));
      return make(REQ_IGNORED, rand48(), $urandom(), 16'($urandom()), rand48());
   endfunction

   initial begin
      req_type_type q;
      board = new();
      board.clear();
      repeat (5) @(posedge clock);
      reset <= 0;
      repeat (2) @(posedge clock);

      // Directed: empty tick, extremes, full table, cancel cases, fire cap.
      send(make(REQ_TICK, '0, '0, '0, '0));
      send(make(REQ_SCHEDULE, DEADLINE_MAX, 32'hFFFF_FFFF, 16'hFFFF, DEADLINE_MAX));
      send(make(REQ_SCHEDULE, 48'd0, 32'd0, 16'h0, 48'd0));
      send(make(REQ_TICK, '0, '0, '0, 48'd10));
      send(make(REQ_CANCEL, '0, '0, 16'h0011, '0));           // one-shot gone
      send(make(REQ_CANCEL, '0, '0, 16'hFFFF, '0));
      send(make(REQ_CANCEL, '0, '0, 16'h0010, '0));           // periodic, valid
      send(make(REQ_CANCEL, '0, '0, 16'h0010, '0));           // now stale
      send(make(REQ_IGNORED, DEADLINE_MAX, '1, '1, DEADLINE_MAX));
      send(make(REQ_SCHEDULE, DEADLINE_MAX - 5, 32'hFFFF_FFFF, '0, '0));
      send(make(REQ_TICK, '0, '0, '0, DEADLINE_MAX));          // saturating re-arm
      for (int i = 0; i < SLOTS + 1; i++)
         send(make(REQ_SCHEDULE, 48'd100, 32'd1, '0, '0));    // last ones are full
      send(make(REQ_TICK, '0, '0, '0, 48'd200));               // hits fire cap
      drain();
      csr_write(32'hFFFF_FFFF);
      for (int i = 0; i < SLOTS; i++)
         send(make(REQ_CANCEL, '0, '0, board.handle_of(i), '0));
      send(make(REQ_TICK, '0, '0, '0, 48'd5));
      drain();
      csr_write(32'd0);
      send(make(REQ_TICK, '0, '0, '0, 48'd6));

      // Random phases, with and without idling, across register settings.
      clock_ms = 48'd1000;
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         csr_write(ph == 0 ? EMPTY_TIMEOUT_RESET : $urandom());
         stalls_on = (ph != 2);
         for (int k = 0; k < N_RANDOM / 4; k++) begin
            q = random_item();
            send(q);
            if (q.req_type == REQ_TICK) clock_ms = q.now_ms;
         end
      end
      drain();

      $display("checked %0d results: %0d expiries, %0d truncated ticks,", board.n_checked,
               board.n_fired, board.n_trunc);
      $display("%0d full-table and %0d unknown-handle responses", board.n_full,
               board.n_missing);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire
